[rtl/brip_pkg.sv]
package brip_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

   localparam logic [5:0] MIN_RADIX = 6'd2;
   localparam logic [5:0] MAX_RADIX = 6'd36;
   localparam logic [5:0] RESET_RADIX = 6'd10;
   localparam logic [6:0] RESET_MAX_DIGITS = 7'd3;
   localparam logic [6:0] DIGITS_SAT = 7'd127;
   localparam logic [6:0] DIGIT_NONE = 7'd64;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_RADIX = 3'd0;
   localparam logic [2:0] CSR_SIGNED_MODE = 3'd1;
   localparam logic [2:0] CSR_MAX_VALUE = 3'd2;
   localparam logic [2:0] CSR_MIN_VALUE = 3'd3;
   localparam logic [2:0] CSR_LIMIT_ENABLE = 3'd4;
   localparam logic [2:0] CSR_MAX_DIGITS = 3'd5;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] LETTER_BASE = 8'd10;

   typedef struct packed {
      logic [5:0]  radix;       // already clamped to the legal range
      logic        signed_mode;
      logic [63:0] max_value;
      logic [63:0] neg_bound;   // magnitude of min_value
      logic        limit_en;
      logic [6:0]  max_digits;
   } cfg_type;

   typedef struct packed {
      logic [63:0] quot;
      logic [5:0]  rem;
   } bound_type;

   typedef struct packed {
      logic [63:0]            value;
      logic                   ok;
      logic [COUNT_WIDTH-1:0] count;
   } rsp_type;

   function automatic logic [6:0] char_digit(input logic [7:0] c);
      logic [6:0] d;
      d = DIGIT_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 7'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = 7'(c - CHAR_UPPER_A + LETTER_BASE);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = 7'(c - CHAR_LOWER_A + LETTER_BASE);
      end
      return d;
   endfunction

endpackage

[rtl/brip_csr.sv]
module brip_csr import brip_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output cfg_type     cfg,
   output logic        cfg_dirty
);

   logic [5:0]  radix_ff;
   logic        signed_mode_ff;
   logic [63:0] max_value_ff;
   logic [63:0] min_value_ff;
   logic        limit_en_ff;
   logic [6:0]  max_digits_ff;
   logic        dirty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RESET_RADIX;
         signed_mode_ff <= 1'b0;
         max_value_ff   <= '1;
         min_value_ff   <= {1'b1, 63'd0};
         limit_en_ff    <= 1'b0;
         max_digits_ff  <= RESET_MAX_DIGITS;
         dirty_ff       <= 1'b1;
      end else begin
         dirty_ff <= csr_we;
         if (csr_we) begin
            case (csr_index)
               CSR_RADIX:        radix_ff       <= csr_wdata[5:0];
               CSR_SIGNED_MODE:  signed_mode_ff <= csr_wdata[0];
               CSR_MAX_VALUE:    max_value_ff   <= csr_wdata;
               CSR_MIN_VALUE:    min_value_ff   <= csr_wdata;
               CSR_LIMIT_ENABLE: limit_en_ff    <= csr_wdata[0];
               CSR_MAX_DIGITS:   max_digits_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      cfg.radix = radix_ff;
      if (radix_ff < MIN_RADIX) begin
         cfg.radix = MIN_RADIX;
      end else if (radix_ff > MAX_RADIX) begin
         cfg.radix = MAX_RADIX;
      end
      cfg.signed_mode = signed_mode_ff;
      cfg.max_value   = max_value_ff;
      cfg.neg_bound   = 64'(64'd0 - min_value_ff);
      cfg.limit_en    = limit_en_ff;
      cfg.max_digits  = max_digits_ff;
   end

   // The bound dividers restart the cycle after any write or reset.
   assign cfg_dirty = dirty_ff;

endmodule

[rtl/brip_div.sv]
module brip_div import brip_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [5:0]  divisor,
   output logic        busy,
   output bound_type   result
);

   logic [63:0]              work_ff;
   logic [5:0]               rem_ff;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   logic [6:0]               trial;
   logic                     fits;

   // Restoring division, one quotient bit a cycle; work_ff shifts the
   // dividend out and the quotient in.
   assign trial = {rem_ff, work_ff[63]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_CNT_WIDTH'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         work_ff <= {work_ff[62:0], fits};
         rem_ff  <= fits ? 6'(trial - {1'b0, divisor}) : trial[5:0];
      end
   end

   assign busy        = cnt_ff != '0;
   assign result.quot = work_ff;
   assign result.rem  = rem_ff;

endmodule

[rtl/brip_core.sv]
module brip_core import brip_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       proc_en,
   input  logic [7:0] char_code,
   input  logic       start_flag,
   input  cfg_type    cfg,
   input  bound_type  pos_bound,
   input  bound_type  neg_bound,
   output logic       emit,
   output rsp_type    rsp
);

   logic [63:0]            acc_ff, acc_in;
   logic [6:0]             digits_ff, digits_in;
   logic [COUNT_WIDTH-1:0] chars_ff, chars_in;
   logic                   open_ff, open_in;
   logic                   neg_ff, neg_in;

   logic [63:0]            acc_cur;
   logic [6:0]             digits_cur, digits_inc;
   logic [COUNT_WIDTH-1:0] chars_cur, chars_inc;
   logic                   open_cur, neg_cur;
   logic                   sign_char, finish;
   logic [6:0]             dgt;
   logic                   dgt_valid;
   bound_type              bnd;
   logic [69:0]            prod;
   logic [63:0]            acc_next;

   always_comb begin
      // A start word discards whatever number was open.
      acc_cur    = start_flag ? '0 : acc_ff;
      digits_cur = start_flag ? '0 : digits_ff;
      chars_cur  = start_flag ? '0 : chars_ff;
      neg_cur    = start_flag ? 1'b0 : neg_ff;
      open_cur   = start_flag | open_ff;

      sign_char = start_flag && cfg.signed_mode &&
                  (char_code == CHAR_MINUS || char_code == CHAR_PLUS);
      dgt       = char_digit(char_code);
      dgt_valid = dgt < {1'b0, cfg.radix};
      bnd       = neg_cur ? neg_bound : pos_bound;
      prod      = acc_cur * cfg.radix;
      acc_next  = prod[63:0] + 64'(dgt[5:0]);

      digits_inc = (digits_cur == DIGITS_SAT) ? digits_cur : digits_cur + 1'b1;
      chars_inc  = (chars_cur == '1) ? chars_cur : chars_cur + 1'b1;

      acc_in    = acc_cur;
      digits_in = digits_cur;
      chars_in  = chars_cur;
      neg_in    = neg_cur;
      finish    = 1'b0;

      if (sign_char) begin
         neg_in   = char_code == CHAR_MINUS;
         chars_in = COUNT_WIDTH'(1);
         finish   = cfg.limit_en && cfg.max_digits == '0;
      end else if (open_cur) begin
         if (cfg.limit_en && digits_cur >= cfg.max_digits) begin
            finish = 1'b1;
         end else if (!dgt_valid) begin
            finish = 1'b1;
         end else if (acc_cur < bnd.quot) begin
            acc_in    = acc_next;
            digits_in = digits_inc;
            chars_in  = chars_inc;
            finish    = cfg.limit_en && digits_inc >= cfg.max_digits;
         end else begin
            // At the quotient a digit up to the remainder still fits, and
            // then nothing more can.
            if (acc_cur == bnd.quot && dgt <= {1'b0, bnd.rem}) begin
               acc_in    = acc_next;
               digits_in = digits_inc;
               chars_in  = chars_inc;
            end
            finish = 1'b1;
         end
      end

      open_in = open_cur && !finish;

      rsp.ok    = digits_in != '0;
      rsp.value = rsp.ok ? (neg_in ? 64'(64'd0 - acc_in) : acc_in) : '0;
      rsp.count = chars_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         digits_ff <= '0;
         chars_ff  <= '0;
         open_ff   <= 1'b0;
         neg_ff    <= 1'b0;
      end else if (proc_en) begin
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         chars_ff  <= chars_in;
         open_ff   <= open_in;
         neg_ff    <= neg_in;
      end
   end

   assign emit = proc_en && finish;

endmodule

[rtl/bounded_radix_integer_parser.sv]
// A word accepted into the input register is parsed from there; a word that ends a
// number has its result written into the result register that drives rsp_valid.
// Throughput: one character per cycle while results are taken and the bounds are
// not being recomputed; a result that waits holds the parse step, and req_ready
// drops once the input register is full. After reset and after every configuration
// write, req_ready is low while two shift-subtract dividers work out the positive
// and negative bound quotient and remainder. Reset is synchronous and active high.
module bounded_radix_integer_parser import brip_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_code,
   input  logic                   req_start_flag,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [63:0]            rsp_value,
   output logic                   rsp_ok,
   output logic [COUNT_WIDTH-1:0] rsp_consumed_count,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_wdata
);

   cfg_type   cfg;
   logic      cfg_dirty;
   logic      pos_busy, neg_busy, busy;
   bound_type pos_bound, neg_bound;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_start_ff;
   logic       out_free, proc_en, req_accept, emit;
   rsp_type    rsp_comb;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   brip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cfg_dirty (cfg_dirty)
   );

   brip_div u_div_pos (
      .clock    (clock),
      .reset    (reset),
      .start    (cfg_dirty),
      .dividend (cfg.max_value),
      .divisor  (cfg.radix),
      .busy     (pos_busy),
      .result   (pos_bound)
   );

   brip_div u_div_neg (
      .clock    (clock),
      .reset    (reset),
      .start    (cfg_dirty),
      .dividend (cfg.neg_bound),
      .divisor  (cfg.radix),
      .busy     (neg_busy),
      .result   (neg_bound)
   );

   assign busy     = cfg_dirty | pos_busy | neg_busy;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign proc_en  = s1_valid_ff && !busy && out_free;

   assign req_ready  = !busy && (!s1_valid_ff || proc_en);
   assign req_accept = req_valid && req_ready;

   brip_core u_core (
      .clock      (clock),
      .reset      (reset),
      .proc_en    (proc_en),
      .char_code  (s1_char_ff),
      .start_flag (s1_start_ff),
      .cfg        (cfg),
      .pos_bound  (pos_bound),
      .neg_bound  (neg_bound),
      .emit       (emit),
      .rsp        (rsp_comb)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (proc_en) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff  <= req_char_code;
         s1_start_ff <= req_start_flag;
      end
      if (emit) begin
         rsp_ff <= rsp_comb;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_ff.value;
   assign rsp_ok             = rsp_ff.ok;
   assign rsp_consumed_count = rsp_ff.count;

endmodule

[rtl/brip_checker.sv]
module brip_checker import brip_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   csr_we,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [63:0]            rsp_value,
   input logic                   rsp_ok,
   input logic [COUNT_WIDTH-1:0] rsp_consumed_count
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_ok) && $stable(rsp_consumed_count))
      else $error("result word changed while stalled");

   // The bounds are being recomputed right after reset.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input accepted right after reset");

   // A configuration write restarts the bound computation.
   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("input accepted right after a configuration write");

   // A failed parse reports zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value == 64'd0)
      else $error("nonzero value on a failed parse");

   // A digit was consumed, so the count cannot be zero.
   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_consumed_count != '0)
      else $error("successful parse with zero consumed characters");

endmodule

bind bounded_radix_integer_parser brip_checker u_brip_checker (.*);

[dv/tb_bounded_radix_integer_parser.sv]
`timescale 1ns / 1ps

module tb_bounded_radix_integer_parser;
   import brip_pkg::*;

   localparam bit [7:0] CHAR_SPACE = 8'h20;

   typedef struct {
      bit         is_csr;
      bit [2:0]   idx;
      bit [63:0]  data;
      bit [7:0]   c;
      bit         st;
      bit         typed;
      rsp_type    want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_char_code = 8'h00;
   logic                   req_start_flag = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [63:0]            rsp_value;
   logic                   rsp_ok;
   logic [COUNT_WIDTH-1:0] rsp_consumed_count;
   logic                   csr_we = 1'b0;
   logic [2:0]             csr_index = 3'd0;
   logic [63:0]            csr_wdata = 64'd0;

   bounded_radix_integer_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .req_start_flag     (req_start_flag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_value          (rsp_value),
      .rsp_ok             (rsp_ok),
      .rsp_consumed_count (rsp_consumed_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Parser copy: configuration registers as written.
   bit [5:0]  cfg_radix = RESET_RADIX;
   bit        cfg_signed = 1'b0;
   bit [63:0] cfg_max = '1;
   bit [63:0] cfg_min = 64'h8000_0000_0000_0000;
   bit        cfg_lim = 1'b0;
   bit [6:0]  cfg_maxd = RESET_MAX_DIGITS;

   // Parser copy: number in progress.
   bit [63:0]            acc = '0;
   bit [6:0]             ndig = '0;
   bit [COUNT_WIDTH-1:0] nchar = '0;
   bit                   num_open = 1'b0;
   bit                   neg = 1'b0;
   bit [63:0]            bnd_q;
   bit [5:0]             bnd_r;

   rsp_type      pending_numbers[$];
   stim_row_type stim_table[$];
   bit [7:0]     word_buf[$];

   int unsigned send_pct = 34;
   int unsigned recv_pct = 49;
   int unsigned fail_count = 0;
   int unsigned results_checked = 0;
   int unsigned words_sent = 0;
   int unsigned counted = 0;
   int unsigned settings_used = 1;

   function automatic bit [5:0] clamped_radix();
      if (cfg_radix < MIN_RADIX) return MIN_RADIX;
      if (cfg_radix > MAX_RADIX) return MAX_RADIX;
      return cfg_radix;
   endfunction

   function automatic void update_bound();
      bit [63:0] b;
      bit [63:0] base;
      base = 64'(clamped_radix());
      b = neg ? (64'd0 - cfg_min) : cfg_max;
      bnd_q = b / base;
      bnd_r = 6'(b % base);
   endfunction

   function automatic bit [6:0] digit_val(input bit [7:0] c);
      bit [6:0] d;
      d = DIGIT_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 7'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = 7'(c - CHAR_UPPER_A) + 7'd10;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = 7'(c - CHAR_LOWER_A) + 7'd10;
      end
      if (d >= 7'(clamped_radix())) d = DIGIT_NONE;
      return d;
   endfunction

   function automatic void bump_chars();
      if (nchar != '1) nchar = nchar + 1'b1;
   endfunction

   function automatic bit limit_reached();
      return cfg_lim && (ndig >= cfg_maxd);
   endfunction

   function automatic void take_digit(input bit [6:0] d);
      acc = acc * 64'(clamped_radix()) + 64'(d);
      if (ndig < DIGITS_SAT) ndig = ndig + 1'b1;
      bump_chars();
   endfunction

   function automatic rsp_type close_number();
      rsp_type r;
      r.ok = (ndig != 0);
      r.value = r.ok ? (neg ? (64'd0 - acc) : acc) : 64'd0;
      r.count = nchar;
      num_open = 1'b0;
      return r;
   endfunction

   // Steps the parser copy by one word; returns 1 when the word ends a number.
   function automatic bit parse_char(input bit [7:0] c, input bit st, output rsp_type r);
      bit [6:0] d;
      r = '0;
      if (st) begin
         num_open = 1'b1;
         acc = '0;
         ndig = '0;
         nchar = '0;
         neg = 1'b0;
         if (cfg_signed && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
            neg = (c == CHAR_MINUS);
            update_bound();
            bump_chars();
            if (limit_reached()) begin
               r = close_number();
               return 1'b1;
            end
            return 1'b0;
         end
         update_bound();
      end
      if (!num_open) return 1'b0;
      if (limit_reached()) begin
         r = close_number();
         return 1'b1;
      end
      d = digit_val(c);
      if (d == DIGIT_NONE) begin
         r = close_number();
         return 1'b1;
      end
      if (acc < bnd_q) begin
         take_digit(d);
         if (limit_reached()) begin
            r = close_number();
            return 1'b1;
         end
         return 1'b0;
      end
      // At the bound quotient the digit fits only up to the remainder, and the
      // number is complete either way.
      if (acc == bnd_q && 6'(d) <= bnd_r) take_digit(d);
      r = close_number();
      return 1'b1;
   endfunction

   function automatic void apply_csr(input bit [2:0] idx, input bit [63:0] data);
      case (idx)
         CSR_RADIX: cfg_radix = data[5:0];
         CSR_SIGNED_MODE: cfg_signed = data[0];
         CSR_MAX_VALUE: cfg_max = data;
         CSR_MIN_VALUE: cfg_min = data;
         CSR_LIMIT_ENABLE: cfg_lim = data[0];
         CSR_MAX_DIGITS: cfg_maxd = data[6:0];
         default: ;
      endcase
      update_bound();
   endfunction

   function automatic void report_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   function automatic bit [7:0] digit_char(input int unsigned d);
      if (d < 10) return 8'(CHAR_ZERO + d);
      return 8'(($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + d - 10);
   endfunction

   function automatic void add_word(input bit [7:0] c, input bit st, input bit typed,
                                    input bit [63:0] v, input bit ok,
                                    input bit [COUNT_WIDTH-1:0] n);
      stim_row_type row;
      row.is_csr = 1'b0;
      row.idx = '0;
      row.data = '0;
      row.c = c;
      row.st = st;
      row.typed = typed;
      row.want.value = v;
      row.want.ok = ok;
      row.want.count = n;
      stim_table = {stim_table, row};
   endfunction

   function automatic void add_csr(input bit [2:0] idx, input bit [63:0] data);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      stim_table = {stim_table, row};
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_pct);
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_numbers.size() == 0) begin
            report_fail($sformatf("unexpected result: value %h ok %0b count %0d",
                                  rsp_value, rsp_ok, rsp_consumed_count));
         end else begin
            want = pending_numbers.pop_front();
            results_checked++;
            if (rsp_value !== want.value || rsp_ok !== want.ok ||
                rsp_consumed_count !== want.count) begin
               report_fail($sformatf(
                  "mismatch: expected value %h ok %0b count %0d, got value %h ok %0b count %0d",
                  want.value, want.ok, want.count, rsp_value, rsp_ok, rsp_consumed_count));
            end
         end
      end
   end

   task automatic send_char(input bit [7:0] c, input bit st, input bit typed,
                            input rsp_type want);
      rsp_type got;
      bit      has;
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_start_flag <= st;
      do @(posedge clock); while (!req_ready);
      counted++;
      words_sent++;
      has = parse_char(c, st, got);
      if (typed) pending_numbers = {pending_numbers, want};
      else if (has) pending_numbers = {pending_numbers, got};
   endtask

   // Holds the sender off until every number has come back, plus the latency.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input bit [2:0] idx, input bit [63:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic randomize_config();
      bit [63:0] v;
      case ($urandom_range(5))
         0: v = 64'd2;
         1: v = 64'd36;
         2: v = 64'd10;
         3: v = 64'd16;
         4: v = 64'($urandom_range(63));
         default: v = 64'($urandom_range(36, 2));
      endcase
      write_csr(CSR_RADIX, v);
      write_csr(CSR_SIGNED_MODE, 64'($urandom_range(1)));
      case ($urandom_range(4))
         0: v = '1;
         1: v = 64'd0;
         2: v = 64'($urandom_range(1000));
         3: v = {$urandom, $urandom};
         default: v = 64'h7FFF_FFFF_FFFF_FFFF;
      endcase
      write_csr(CSR_MAX_VALUE, v);
      case ($urandom_range(4))
         0: v = 64'h8000_0000_0000_0000;
         1: v = 64'd0;
         2: v = 64'd0 - 64'($urandom_range(1000));
         3: v = {1'b1, 31'($urandom), $urandom};
         default: v = {$urandom, $urandom};
      endcase
      write_csr(CSR_MIN_VALUE, v);
      write_csr(CSR_LIMIT_ENABLE, 64'($urandom_range(2) == 0));
      case ($urandom_range(3))
         0: v = 64'd0;
         1: v = 64'd64;
         2: v = 64'($urandom_range(5, 1));
         default: v = 64'($urandom_range(127));
      endcase
      write_csr(CSR_MAX_DIGITS, v);
      settings_used++;
   endtask

   // One number: mostly well formed with random digits, digits close to the bound or
   // leading zeros, the rest noise with random start flags.
   task automatic send_number();
      bit [63:0]   b;
      bit [5:0]    base;
      bit [7:0]    sign_c;
      bit          use_sign;
      int unsigned kind;
      int unsigned n;
      base = clamped_radix();
      kind = $urandom_range(9);
      word_buf.delete();
      if (kind >= 8) begin
         n = $urandom_range(6, 1);
         repeat (n) send_char(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, '0);
         return;
      end
      use_sign = ($urandom_range(2) == 0);
      sign_c = $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS;
      if (kind <= 3) begin
         n = ($urandom_range(3) == 0) ? $urandom_range(25) : $urandom_range(8);
         repeat (n) word_buf = {word_buf, digit_char($urandom_range(base - 1))};
      end else if (kind <= 6) begin
         b = (use_sign && cfg_signed && sign_c == CHAR_MINUS) ? (64'd0 - cfg_min) : cfg_max;
         do begin
            word_buf.push_front(digit_char(int'(b % 64'(base))));
            b = b / 64'(base);
         end while (b != 0);
         if ($urandom_range(1)) word_buf[word_buf.size() - 1] =
            digit_char($urandom_range(base - 1));
         repeat ($urandom_range(2)) word_buf = {word_buf, digit_char($urandom_range(base - 1))};
      end else begin
         repeat ($urandom_range(5, 1)) word_buf = {word_buf, CHAR_ZERO};
         repeat ($urandom_range(6)) word_buf = {word_buf, digit_char($urandom_range(base - 1))};
      end
      if (use_sign) word_buf.push_front(sign_c);
      if ($urandom_range(3) != 0) word_buf = {word_buf, 8'($urandom_range(255))};
      foreach (word_buf[i]) send_char(word_buf[i], i == 0, 1'b0, '0);
   endtask

   initial begin
      #2_000_000;
      $display("Timed out with %0d numbers still expected.", pending_numbers.size());
      $display("FAIL bounded_radix_integer_parser");
      $finish;
   end

   initial begin
      update_bound();

      // Reset configuration first: radix 10, unsigned, full range.
      add_word("q", 1'b0, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word(8'hFF, 1'b1, 1'b1, 64'd0, 1'b0, 16'd0);
      add_word("9", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word(8'h00, 1'b0, 1'b1, 64'd9, 1'b1, 16'd1);
      add_word("7", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("4", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("-", 1'b0, 1'b1, 64'd4, 1'b1, 16'd1);
      // A digit equal to the bound remainder is taken, one above it is not.
      add_csr(CSR_MAX_VALUE, 64'd25);
      add_word("2", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("5", 1'b0, 1'b1, 64'd25, 1'b1, 16'd2);
      add_word("2", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("6", 1'b0, 1'b1, 64'd2, 1'b1, 16'd1);
      add_csr(CSR_SIGNED_MODE, 64'd1);
      add_csr(CSR_MIN_VALUE, -64'd7);
      add_word("-", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("8", 1'b0, 1'b1, 64'd0, 1'b0, 16'd1);
      add_word("-", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("7", 1'b0, 1'b1, -64'd7, 1'b1, 16'd2);
      add_word("+", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("9", 1'b0, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("Z", 1'b0, 1'b1, 64'd9, 1'b1, 16'd2);
      // Radix below the legal range, and a digit limit of zero.
      add_csr(CSR_RADIX, 64'd0);
      add_csr(CSR_LIMIT_ENABLE, 64'd1);
      add_csr(CSR_MAX_DIGITS, 64'd0);
      add_word("-", 1'b1, 1'b1, 64'd0, 1'b0, 16'd1);
      add_word("1", 1'b1, 1'b1, 64'd0, 1'b0, 16'd0);
      // Radix above the legal range and a positive min_value.
      add_csr(CSR_MAX_DIGITS, 64'd2);
      add_csr(CSR_RADIX, 64'd63);
      add_csr(CSR_MIN_VALUE, 64'd5);
      add_word("-", 1'b1, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("z", 1'b0, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("Z", 1'b0, 1'b0, 64'd0, 1'b0, 16'd0);
      add_word("1", 1'b0, 1'b0, 64'd0, 1'b0, 16'd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr) begin
            wait_drain();
            write_csr(stim_table[i].idx, stim_table[i].data);
         end else begin
            send_char(stim_table[i].c, stim_table[i].st, stim_table[i].typed,
                      stim_table[i].want);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_pct = (ph == 0) ? 34 : (ph == 1) ? 49 : 0;
         recv_pct = (ph == 0) ? 49 : (ph == 1) ? 34 : 0;
         for (int s = 0; s < 4; s++) begin
            wait_drain();
            randomize_config();
            counted = 0;
            while (counted < 60) begin
               if ($urandom_range(49) == 0) wait_drain();
               send_number();
            end
         end
      end

      // A long run of zeros saturates the digit count.
      wait_drain();
      write_csr(CSR_RADIX, 64'd10);
      write_csr(CSR_SIGNED_MODE, 64'd0);
      write_csr(CSR_MAX_VALUE, '1);
      write_csr(CSR_LIMIT_ENABLE, 64'd0);
      settings_used++;
      send_char(CHAR_ZERO, 1'b1, 1'b0, '0);
      repeat (129) send_char(CHAR_ZERO, 1'b0, 1'b0, '0);
      send_char(CHAR_SPACE, 1'b0, 1'b0, '0);

      wait_drain();
      repeat (8) @(posedge clock);
      if (pending_numbers.size() != 0) begin
         report_fail($sformatf("%0d expected numbers never arrived", pending_numbers.size()));
      end
      $display("Sent %0d words under %0d register settings, checked %0d numbers, %0d failures.",
               words_sent, settings_used, results_checked, fail_count);
      if (fail_count == 0) begin
         $display("PASS bounded_radix_integer_parser");
      end else begin
         $display("FAIL bounded_radix_integer_parser");
      end
      $finish;
   end

endmodule
